[rtl/zero_crossing_pitch_tracker_unit_assert.svh]
// Assertion macros for the pitch tracker checker.
`ifndef ZERO_CROSSING_PITCH_TRACKER_UNIT_ASSERT_SVH
`define ZERO_CROSSING_PITCH_TRACKER_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define ZCPT_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("zcpt check failed");
// Next-cycle implication checked outside reset.
`define ZCPT_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("zcpt check failed");
`endif

[rtl/zcpt_pkg.sv]
// Package: shared types, widths and state codes for the pitch tracker.
`default_nettype none
package zcpt_pkg;
  localparam int SampleBits = 16;
  localparam int WindowSamples = 1024;
  localparam int MinPartial = 256;
  localparam int CntBits = 11;
  localparam int RateBits = 18;
  localparam int MinBits = 11;
  localparam int MaxBits = 13;
  localparam int PitchBits = 21;
  localparam int SmoothBits = 24;
  localparam int LogBits = 21;

  // Register byte addresses.
  localparam logic [3:0] ADDR_RATE = 4'd0;
  localparam logic [3:0] ADDR_MIN = 4'd4;
  localparam logic [3:0] ADDR_MAX = 4'd8;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_DIV   = 4'd2;
  localparam logic [3:0] ST_ACC   = 4'd3;
  localparam logic [3:0] ST_LOGP  = 4'd4;
  localparam logic [3:0] ST_LOGN  = 4'd5;
  localparam logic [3:0] ST_LOGX  = 4'd6;
  localparam logic [3:0] ST_MDIV  = 4'd7;
  localparam logic [3:0] ST_SMTH  = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  // Operand selection for the shared log unit.
  localparam logic [1:0] LSEL_P = 2'd0;
  localparam logic [1:0] LSEL_MIN = 2'd1;
  localparam logic [1:0] LSEL_MAX = 2'd2;

  typedef struct packed {
    logic       count;     // update crossing and window counters
    logic       mul;       // form the estimate numerator
    logic       div_start; // start estimate divide
    logic       accept;    // check estimate and clear counters
    logic       log_start;
    logic [1:0] log_sel;
    logic       log_store;
    logic       mdiv_start;
    logic       smooth;
  } zcpt_cmd_t;

  typedef struct packed {
    logic check;      // window is due for an estimate
    logic div_done;
    logic log_done;
    logic mdiv_done;
  } zcpt_status_t;
endpackage
`default_nettype wire

[rtl/zero_crossing_pitch_tracker_unit.sv]
// Top level: configuration registers, controller and datapath.
`default_nettype none
// Pitch tracker: one sample word at a time. Each accepted word runs through
// the bit-serial estimate divider (37 steps, only when an estimate is due and
// a crossing was counted), three passes of the shared log2 unit (16 squarings
// each) and the bit-serial mapping divider (37 steps). The input stalls while
// a word is in work; the result stays on the outputs until it is taken.
module zero_crossing_pitch_tracker_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire [15:0]  sample,
  input  wire         block_end,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [15:0] pitch_cv,
  output logic [15:0] confidence,
  output logic [12:0] pitch_hz,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire [3:0]   paddr,
  input  wire [31:0]  pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import zcpt_pkg::*;

  logic [RateBits-1:0] sample_rate;
  logic [MinBits-1:0] min_freq;
  logic [MaxBits-1:0] max_freq;
  zcpt_cmd_t cmd;
  zcpt_status_t status;

  assign pready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= RateBits'(48000);
      min_freq <= MinBits'(80);
      max_freq <= MaxBits'(2000);
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        ADDR_RATE: sample_rate <= pwdata[RateBits-1:0];
        ADDR_MIN:  min_freq <= pwdata[MinBits-1:0];
        ADDR_MAX:  max_freq <= pwdata[MaxBits-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (paddr)
      ADDR_RATE: prdata = 32'(sample_rate);
      ADDR_MIN:  prdata = 32'(min_freq);
      ADDR_MAX:  prdata = 32'(max_freq);
      default:   prdata = '0;
    endcase
  end

  zcpt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
  );

  zcpt_datapath u_dp (
    .clk(clk), .rst(rst), .sample(sample), .block_end(block_end),
    .sample_rate(sample_rate), .min_freq(min_freq), .max_freq(max_freq),
    .cmd(cmd), .status(status), .pitch_cv(pitch_cv), .confidence(confidence),
    .pitch_hz(pitch_hz)
  );
endmodule
`default_nettype wire

[rtl/zcpt_ctrl.sv]
// Controller: sequences one sample word through the datapath steps.
`default_nettype none
module zcpt_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire                  out_stall,
  input  zcpt_pkg::zcpt_status_t status,
  output zcpt_pkg::zcpt_cmd_t  cmd
);
  import zcpt_pkg::*;
  logic [3:0] state, state_next;
  logic [1:0] lsel, lsel_next;

  assign in_stall = (state != ST_IDLE);

  // Advance the step sequence.
  always_comb begin
    state_next = state;
    lsel_next = lsel;
    cmd = '0;
    cmd.log_sel = lsel;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.count = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (status.check) begin
          cmd.mul = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_LOGP;
        end
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (status.div_done) begin
          cmd.accept = 1'b1;
          state_next = ST_LOGP;
        end
      end
      ST_LOGP: begin
        cmd.log_start = 1'b1;
        cmd.log_sel = LSEL_P;
        lsel_next = LSEL_P;
        state_next = ST_LOGX;
      end
      ST_LOGX: begin
        if (status.log_done) begin
          cmd.log_store = 1'b1;
          if (lsel == LSEL_MAX) begin
            state_next = ST_MDIV;
          end else begin
            lsel_next = (lsel == LSEL_P) ? LSEL_MIN : LSEL_MAX;
            state_next = ST_LOGN;
          end
        end
      end
      ST_LOGN: begin
        cmd.log_start = 1'b1;
        state_next = ST_LOGX;
      end
      ST_MDIV: begin
        cmd.mdiv_start = 1'b1;
        state_next = ST_SMTH;
      end
      ST_SMTH: begin
        if (status.mdiv_done) begin
          cmd.smooth = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      lsel <= LSEL_P;
    end else begin
      state <= state_next;
      lsel <= lsel_next;
    end
  end
endmodule
`default_nettype wire

[rtl/zcpt_datapath.sv]
// Datapath: counters, estimate divider, log unit, mapping divider, smoothers.
`default_nettype none
module zcpt_datapath (
  input  wire                          clk,
  input  wire                          rst,
  input  wire [zcpt_pkg::SampleBits-1:0] sample,
  input  wire                          block_end,
  input  wire [zcpt_pkg::RateBits-1:0] sample_rate,
  input  wire [zcpt_pkg::MinBits-1:0]  min_freq,
  input  wire [zcpt_pkg::MaxBits-1:0]  max_freq,
  input  zcpt_pkg::zcpt_cmd_t          cmd,
  output zcpt_pkg::zcpt_status_t       status,
  output logic [15:0]                  pitch_cv,
  output logic [15:0]                  confidence,
  output logic [12:0]                  pitch_hz
);
  import zcpt_pkg::*;

  logic [SampleBits-1:0] previous_sample;
  logic [CntBits-1:0] crossing_count, window_count;
  logic [PitchBits-1:0] held_pitch;
  logic pitch_found;
  logic [SmoothBits-1:0] smoothed_cv, smoothed_confidence;
  logic check;

  // Crossing detect on the incoming word.
  logic cur_neg, cur_pos, prev_neg, prev_pos, crossing;
  assign cur_neg = sample[SampleBits-1];
  assign cur_pos = !cur_neg && (sample != '0);
  assign prev_neg = previous_sample[SampleBits-1];
  assign prev_pos = !prev_neg && (previous_sample != '0);
  assign crossing = (prev_neg && !cur_neg) || (prev_pos && !cur_pos);

  // Count and flag the estimate check.
  logic [CntBits-1:0] wc_inc;
  assign wc_inc = window_count + CntBits'(1);
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      crossing_count <= '0;
      window_count <= '0;
      check <= 1'b0;
    end else if (cmd.count) begin
      previous_sample <= sample;
      crossing_count <= crossing_count + CntBits'(crossing);
      window_count <= wc_inc;
      check <= (32'(wc_inc) >= WindowSamples) ||
               (block_end && (32'(wc_inc) >= MinPartial));
    end else if (cmd.accept) begin
      crossing_count <= '0;
      window_count <= '0;
    end else if (cmd.mul && crossing_count == '0) begin
      crossing_count <= '0;
      window_count <= '0;
    end
  end

  // Numerator rate*crossings*256; divisor 2*count. Quotient fits 37 bits.
  logic [28:0] num;
  always_ff @(posedge clk) begin
    if (cmd.mul) num <= 29'(sample_rate) * 29'(crossing_count);
  end

  // Restoring divider for the estimate, one quotient bit a cycle.
  localparam int EstQ = 37; // num<<8 has 37 bits
  logic [EstQ-1:0] ediv_q;
  logic [CntBits+1:0] ediv_r;
  logic [5:0] ediv_n;
  logic ediv_busy, ediv_done;
  logic [CntBits+1:0] ediv_trial;
  logic [CntBits:0] ediv_d;
  assign ediv_d = {window_count, 1'b0};
  assign ediv_trial = {ediv_r[CntBits:0], ediv_q[EstQ-1]};
  always_ff @(posedge clk) begin
    if (rst) begin
      ediv_busy <= 1'b0;
      ediv_done <= 1'b0;
    end else if (cmd.div_start) begin
      ediv_q <= {num, 8'd0};
      ediv_r <= '0;
      ediv_n <= 6'(EstQ);
      ediv_busy <= (crossing_count != '0);
      ediv_done <= (crossing_count == '0);
    end else if (ediv_busy) begin
      if (ediv_trial >= {1'b0, ediv_d}) begin
        ediv_r <= ediv_trial - {1'b0, ediv_d};
        ediv_q <= {ediv_q[EstQ-2:0], 1'b1};
      end else begin
        ediv_r <= ediv_trial;
        ediv_q <= {ediv_q[EstQ-2:0], 1'b0};
      end
      ediv_n <= ediv_n - 6'd1;
      if (ediv_n == 6'd1) begin
        ediv_busy <= 1'b0;
        ediv_done <= 1'b1;
      end
    end else begin
      ediv_done <= 1'b0;
    end
  end

  // Accept the estimate when inside the limits.
  logic est_ok;
  assign est_ok = (crossing_count != '0) &&
                  (ediv_q >= EstQ'({min_freq, 8'd0})) &&
                  (ediv_q <= EstQ'({max_freq, 8'd0}));
  always_ff @(posedge clk) begin
    if (rst) begin
      held_pitch <= '0;
      pitch_found <= 1'b0;
    end else if (cmd.accept && est_ok) begin
      held_pitch <= ediv_q[PitchBits-1:0];
      pitch_found <= 1'b1;
    end
  end

  // Shared log2 unit: one squaring per cycle.
  logic [PitchBits-1:0] lx_raw, lx;
  always_comb begin
    unique case (cmd.log_sel)
      LSEL_MIN: lx_raw = PitchBits'({min_freq, 8'd0});
      LSEL_MAX: lx_raw = PitchBits'({max_freq, 8'd0});
      default:  lx_raw = held_pitch;
    endcase
    lx = (lx_raw < PitchBits'(256)) ? PitchBits'(256) : lx_raw;
  end
  logic [4:0] lz_e;
  always_comb begin
    lz_e = 5'd0;
    for (int i = 0; i < PitchBits; i++) if (lx[i]) lz_e = 5'(i);
  end
  logic [31:0] lm;
  logic [15:0] lfrac;
  logic [4:0] le;
  logic [4:0] lcnt;
  logic lbusy, ldone;
  logic [63:0] lsq;
  assign lsq = 64'(lm) * 64'(lm);
  always_ff @(posedge clk) begin
    if (rst) begin
      lbusy <= 1'b0;
      ldone <= 1'b0;
    end else if (cmd.log_start) begin
      lm <= 32'(lx) << (5'd30 - lz_e);
      le <= lz_e;
      lfrac <= '0;
      lcnt <= 5'd16;
      lbusy <= 1'b1;
      ldone <= 1'b0;
    end else if (lbusy) begin
      if (lsq[61]) begin
        lm <= lsq[62:31];
        lfrac <= {lfrac[14:0], 1'b1};
      end else begin
        lm <= lsq[61:30];
        lfrac <= {lfrac[14:0], 1'b0};
      end
      lcnt <= lcnt - 5'd1;
      if (lcnt == 5'd1) begin
        lbusy <= 1'b0;
        ldone <= 1'b1;
      end
    end else begin
      ldone <= 1'b0;
    end
  end
  logic [LogBits-1:0] lresult, lp, lmin, lmax;
  assign lresult = {le, lfrac};
  always_ff @(posedge clk) begin
    if (cmd.log_store) begin
      unique case (cmd.log_sel)
        LSEL_MIN: lmin <= lresult;
        LSEL_MAX: lmax <= lresult;
        default:  lp <= lresult;
      endcase
    end
  end

  // Mapping divider: (lp-lmin)<<16 / (lmax-lmin), saturated.
  localparam int MQ = 37;
  logic [MQ-1:0] mq;
  logic [LogBits:0] mr;
  logic [LogBits-1:0] md;
  logic [5:0] mn;
  logic mbusy, mdone, mzero;
  logic [LogBits:0] mtrial;
  assign mtrial = {mr[LogBits-1:0], mq[MQ-1]};
  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mdone <= 1'b0;
    end else if (cmd.mdiv_start) begin
      mzero <= (lmax <= lmin) || (lp <= lmin);
      mq <= MQ'({lp - lmin, 16'd0});
      md <= lmax - lmin;
      mr <= '0;
      mn <= 6'(MQ);
      mbusy <= 1'b1;
      mdone <= 1'b0;
    end else if (mbusy) begin
      if (mtrial >= {1'b0, md}) begin
        mr <= mtrial - {1'b0, md};
        mq <= {mq[MQ-2:0], 1'b1};
      end else begin
        mr <= mtrial;
        mq <= {mq[MQ-2:0], 1'b0};
      end
      mn <= mn - 6'd1;
      if (mn == 6'd1) begin
        mbusy <= 1'b0;
        mdone <= 1'b1;
      end
    end else begin
      mdone <= 1'b0;
    end
  end
  logic [15:0] cv_target;
  assign cv_target = mzero ? 16'd0 : ((mq > MQ'(65535)) ? 16'hFFFF : mq[15:0]);

  // One-pole smoothers; divide by 20 via reciprocal and correction.
  function automatic logic [SmoothBits-1:0] smooth20(input logic [SmoothBits-1:0] s,
                                                     input logic [15:0] t);
    logic [29:0] sum;
    logic [61:0] prod;
    logic [29:0] q, r;
    sum = 30'(s) * 30'd19 + 30'({t, 8'd0}) + 30'd10;
    prod = 62'(sum) * 62'd214748365; // ceil(2^32/20)
    q = prod[61:32];
    r = sum - q * 30'd20;
    if (r >= 30'd20) q = q + 30'd1;
    return q[SmoothBits-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_cv <= '0;
      smoothed_confidence <= '0;
    end else if (cmd.smooth) begin
      smoothed_cv <= smooth20(smoothed_cv, cv_target);
      smoothed_confidence <= smooth20(smoothed_confidence,
                                      pitch_found ? 16'h8000 : 16'h0000);
    end
  end

  function automatic logic [15:0] smooth_out(input logic [SmoothBits-1:0] s);
    logic [SmoothBits:0] o;
    o = {1'b0, s} + (SmoothBits+1)'(128);
    return (o[SmoothBits:8] > 17'd65535) ? 16'hFFFF : o[23:8];
  endfunction

  assign pitch_cv = smooth_out(smoothed_cv);
  assign confidence = smooth_out(smoothed_confidence);
  assign pitch_hz = held_pitch[20:8];

  assign status.check = check;
  assign status.div_done = ediv_done;
  assign status.log_done = ldone;
  assign status.mdiv_done = mdone;
endmodule
`default_nettype wire

[rtl/zcpt_checker.sv]
// Port checker for the pitch tracker, bound to the top level.
`default_nettype none
`include "zero_crossing_pitch_tracker_unit_assert.svh"
module zcpt_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [15:0] confidence,
  input wire [12:0] pitch_hz,
  input wire        pready
);
  `ZCPT_ASSERT_IMP(a_no_accept_while_out, clk, rst, out_valid, !(in_valid && !in_stall))
  `ZCPT_ASSERT_NEXT(a_out_holds, clk, rst, out_valid && out_stall, out_valid && $stable(pitch_hz))
  `ZCPT_ASSERT_IMP(a_conf_bound, clk, rst, 1'b1, confidence <= 16'h8000)
  `ZCPT_ASSERT_IMP(a_ready, clk, rst, 1'b1, pready)
endmodule
bind zero_crossing_pitch_tracker_unit zcpt_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .confidence(confidence),
  .pitch_hz(pitch_hz), .pready(pready)
);
`default_nettype wire

[tb/zero_crossing_pitch_tracker_unit_tb.sv]
// Testbench for the zero-crossing pitch tracker: random audio words against a bit-exact predictor.
`timescale 1ns / 100ps
module zero_crossing_pitch_tracker_unit_tb;
  import zcpt_pkg::*;

  localparam logic [3:0] ADDR_UNUSED = 4'd12;
  localparam int CycleLimit = 2000000;
  localparam int SettleCycles = 300;

  typedef struct {
    logic [15:0] smp;
    logic        last;
  } audio_word_t;

  typedef struct {
    logic [15:0] cv;
    logic [15:0] conf;
    logic [12:0] hz;
  } pitch_word_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] sample;
  logic        block_end;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] pitch_cv;
  logic [15:0] confidence;
  logic [12:0] pitch_hz;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  zero_crossing_pitch_tracker_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample), .block_end(block_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .pitch_cv(pitch_cv), .confidence(confidence), .pitch_hz(pitch_hz),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  audio_word_t audio_pending[$];
  pitch_word_t pitch_expected[$];
  int errors = 0;
  int cycles = 0;

  // Predictor copy of configuration and state
  logic [17:0] cfg_rate;
  logic [10:0] cfg_min;
  logic [12:0] cfg_max;
  logic [15:0] prev_smp;
  logic [10:0] cross_cnt;
  logic [10:0] win_cnt;
  logic [20:0] held_q8;
  logic        locked;
  logic [23:0] cv_state;
  logic [23:0] conf_state;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Log2 in Q16: integer exponent plus 16 fraction bits from repeated squaring
  function automatic logic [31:0] log2_q16(input logic [31:0] xin);
    logic [31:0] x;
    logic [31:0] e;
    logic [63:0] m;
    logic [31:0] frac;
    x = (xin == 0) ? 32'd1 : xin;
    e = 31;
    frac = 0;
    while (x[e] == 1'b0) e = e - 1;
    if (e <= 30) m = 64'(x) << (30 - e);
    else m = 64'(x >> 1);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        frac = frac | 32'd1;
        m = m >> 1;
      end
    end
    return (e << 16) | frac;
  endfunction

  function automatic logic [31:0] floor_1hz(input logic [31:0] q8);
    return (q8 < 256) ? 32'd256 : q8;
  endfunction

  function automatic logic [15:0] cv_target();
    logic [31:0] lmin;
    logic [31:0] lmax;
    logic [31:0] lp;
    logic [63:0] q;
    lmin = log2_q16(floor_1hz(32'(cfg_min) << 8));
    lmax = log2_q16(floor_1hz(32'(cfg_max) << 8));
    lp = log2_q16(floor_1hz(32'(held_q8)));
    if (lmax <= lmin || lp <= lmin) return 16'd0;
    q = (64'(lp - lmin) << 16) / 64'(lmax - lmin);
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic logic [23:0] smooth_step(input logic [23:0] s, input logic [15:0] t);
    logic [63:0] acc;
    acc = (64'd19 * 64'(s) + (64'(t) << 8) + 64'd10) / 64'd20;
    return acc[23:0];
  endfunction

  function automatic logic [15:0] smooth_round(input logic [23:0] s);
    logic [31:0] o;
    o = (32'(s) + 32'd128) >> 8;
    return (o > 65535) ? 16'hFFFF : o[15:0];
  endfunction

  // Advance the predictor by one word and queue its result
  task automatic track_pitch(input logic [15:0] smp, input logic last);
    logic cur_neg;
    logic cur_pos;
    logic prev_neg;
    logic prev_pos;
    logic [63:0] num;
    logic [63:0] est;
    pitch_word_t r;
    cur_neg = smp[15];
    cur_pos = !cur_neg && smp != 0;
    prev_neg = prev_smp[15];
    prev_pos = !prev_neg && prev_smp != 0;
    if ((prev_neg && !cur_neg) || (prev_pos && !cur_pos)) cross_cnt = cross_cnt + 1;
    prev_smp = smp;
    win_cnt = win_cnt + 1;
    if (win_cnt >= WindowSamples || (last && win_cnt >= MinPartial)) begin
      if (cross_cnt > 0) begin
        num = 64'(cfg_rate) * 64'(cross_cnt) * 64'd256;
        est = num / (64'd2 * 64'(win_cnt));
        if (est >= (64'(cfg_min) << 8) && est <= (64'(cfg_max) << 8)) begin
          held_q8 = est[20:0];
          locked = 1'b1;
        end
      end
      cross_cnt = 0;
      win_cnt = 0;
    end
    cv_state = smooth_step(cv_state, cv_target());
    conf_state = smooth_step(conf_state, locked ? 16'd32768 : 16'd0);
    r.cv = smooth_round(cv_state);
    r.conf = smooth_round(conf_state);
    r.hz = held_q8[20:8];
    pitch_expected = {pitch_expected, r};
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Sender: bursts of random length with random gaps
  int burst_left = 8;
  int gap_left = 0;
  always @(posedge clk) begin
    audio_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
      sample <= 16'd0;
      block_end <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_pitch(sample, block_end);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (audio_pending.size() > 0) begin
          w = audio_pending.pop_front();
          sample <= w.smp;
          block_end <= w.last;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted on its own
  int hold_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (cycles == 20000) hold_left <= 1500;
      else if (hold_left > 0) hold_left <= hold_left - 1;
    end
  end

  // Receiver: compare each taken word and stall on a changing pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    pitch_word_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pitch_expected.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          e = pitch_expected.pop_front();
          if (pitch_cv !== e.cv) report_mismatch("pitch_cv", pitch_cv, e.cv);
          if (confidence !== e.conf) report_mismatch("confidence", confidence, e.conf);
          if (pitch_hz !== e.hz) report_mismatch("pitch_hz", pitch_hz, e.hz);
        end
      end
      if (cycles % 500 == 0) stall_mode = $urandom_range(0, 2);
      out_stall <= (hold_left > 0) ||
                   (stall_mode == 1 && $urandom_range(0, 3) == 0) ||
                   (stall_mode == 2 && $urandom_range(0, 3) != 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_RATE) cfg_rate = data[17:0];
    else if (addr == ADDR_MIN) cfg_min = data[10:0];
    else if (addr == ADDR_MAX) cfg_max = data[12:0];
  endtask

  task automatic push_word(input logic [15:0] smp, input logic last);
    audio_word_t w;
    w.smp = smp;
    w.last = last;
    audio_pending = {audio_pending, w};
  endtask

  task automatic drain();
    while (audio_pending.size() > 0 || in_valid || pitch_expected.size() > 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Random audio: mostly square-ish tones, some silence or constant level and noise
  task automatic push_random(input int count);
    int n;
    int len;
    int period;
    int amp;
    int kind;
    logic [15:0] v;
    n = 0;
    while (n < count) begin
      kind = $urandom_range(0, 9);
      len = (kind == 7) ? $urandom_range(256, 600) : $urandom_range(40, 400);
      if (len > count - n) len = count - n;
      if (kind < 7) begin
        period = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 8) : $urandom_range(8, 400);
        for (int i = 0; i < len; i++) begin
          amp = ($urandom_range(0, 7) == 0) ? 32767 : $urandom_range(0, 32767);
          if ((i % period) < period / 2) v = 16'(amp);
          else v = 16'(-amp - ($urandom_range(0, 1)));
          push_word(v, (i == len - 1) && $urandom_range(0, 1));
        end
      end else if (kind == 7) begin
        v = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
        for (int i = 0; i < len; i++) push_word(v, i == len - 1);
      end else begin
        for (int i = 0; i < len; i++) push_word(16'($urandom), $urandom_range(0, 7) == 0);
      end
      n += len;
    end
  endtask

  task automatic run_phase(input int rate, input int fmin, input int fmax, input int count);
    reg_write(ADDR_RATE, 32'(rate));
    reg_write(ADDR_MIN, 32'(fmin));
    reg_write(ADDR_MAX, 32'(fmax));
    push_random(count);
    drain();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 4'd0;
    pwdata = 32'd0;
    cfg_rate = 18'd48000;
    cfg_min = 11'd80;
    cfg_max = 13'd2000;
    prev_smp = 0;
    cross_cnt = 0;
    win_cnt = 0;
    held_q8 = 0;
    locked = 1'b0;
    cv_state = 0;
    conf_state = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, crossings into and out of zero, short block end
    push_word(16'h7FFF, 1'b0);
    push_word(16'h8000, 1'b0);
    push_word(16'h7FFF, 1'b0);
    push_word(16'h0000, 1'b0);
    push_word(16'h0001, 1'b0);
    push_word(16'hFFFF, 1'b0);
    push_word(16'h0000, 1'b1);
    push_word(16'h8000, 1'b0);
    push_word(16'h0000, 1'b0);
    push_word(16'h0000, 1'b0);
    push_word(16'hFFFF, 1'b1);
    push_word(16'h5555, 1'b0);
    push_word(16'hAAAA, 1'b0);
    push_word(16'h1234, 1'b1);
    drain();

    // Ignored write to an unmapped register
    reg_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    run_phase(48000, 80, 2000, 300);
    run_phase(192000, 20, 8000, 300);
    run_phase(8000, 2000, 100, 260);
    run_phase(44100, 440, 440, 260);
    run_phase(0, 0, 8000, 260);
    run_phase(262143, 2047, 8191, 260);
    run_phase(8000, 20, 100, 300);

    while (pitch_expected.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl
rtl/zcpt_pkg.sv
rtl/zcpt_ctrl.sv
rtl/zcpt_datapath.sv
rtl/zero_crossing_pitch_tracker_unit.sv
rtl/zcpt_checker.sv
tb/zero_crossing_pitch_tracker_unit_tb.sv
